@@ sv/tss_pkg.sv @@
package tss_pkg;

  localparam int SLOT_W  = 3;
  localparam int VAL_W   = 16;
  localparam int ACNT_W  = 4;
  localparam int RES_MAX = 8;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_DISPATCH   = 3'd1,
    OP_SETUP_PER  = 3'd2,
    OP_SETUP_ONCE = 3'd3,
    OP_JOIN       = 3'd4,
    OP_DROP       = 3'd5,
    OP_SET_CD     = 3'd6,
    OP_SET_RL     = 3'd7
  } op_t;

  typedef struct packed {
    op_t  op;
    logic load;
    logic scan_clr;
    logic apply;
    logic rd_scan;
    logic rd_tgt;
    logic tick_step;
    logic disp_step;
    logic idx_inc;
    logic st_out;
  } tss_cmd_t;

  typedef struct packed {
    logic idx_last;
    logic disp_hit;
    logic disp_last;
    logic out_free;
  } tss_stat_t;

endpackage

@@ sv/tss_ctrl.sv @@
module tss_ctrl
  import tss_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [2:0]      in_cmd,
  input  tss_stat_t       stat,
  output tss_cmd_t        cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPLY,
    S_RD,
    S_EX,
    S_ST_RD,
    S_ST_OUT
  } state_t;

  state_t state_r, state_nxt;
  op_t    op_r;
  op_t    in_op;

  assign in_op    = op_t'(in_cmd);
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.op    = op_r;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load     = 1'b1;
          cmd.scan_clr = 1'b1;
          if (in_op == OP_TICK || in_op == OP_DISPATCH) begin
            state_nxt = S_RD;
          end else begin
            state_nxt = S_APPLY;
          end
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = S_ST_RD;
      end
      S_RD: begin
        cmd.rd_scan = 1'b1;
        state_nxt   = S_EX;
      end
      S_EX: begin
        if (op_r == OP_TICK) begin
          cmd.tick_step = 1'b1;
          if (stat.idx_last) begin
            state_nxt = S_ST_RD;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_RD;
          end
        end else if (stat.disp_hit) begin
          if (stat.out_free) begin
            cmd.disp_step = 1'b1;
            if (stat.disp_last || stat.idx_last) begin
              state_nxt = S_IDLE;
            end else begin
              cmd.idx_inc = 1'b1;
              state_nxt   = S_RD;
            end
          end
        end else if (stat.idx_last) begin
          state_nxt = S_ST_RD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_RD;
        end
      end
      S_ST_RD: begin
        cmd.rd_tgt = 1'b1;
        state_nxt  = S_ST_OUT;
      end
      S_ST_OUT: begin
        if (stat.out_free) begin
          cmd.st_out = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_TICK;
    end else begin
      state_r <= state_nxt;
      if (cmd.load) begin
        op_r <= in_op;
      end
    end
  end

endmodule

@@ sv/tss_dp.sv @@
module tss_dp
  import tss_pkg::*;
#(
  parameter int NUM_SLOTS   = 8,
  parameter int COUNT_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tss_cmd_t          cmd,
  output tss_stat_t         stat,
  input  logic [SLOT_W-1:0] in_slot,
  input  logic              in_use_current,
  input  logic [VAL_W-1:0]  in_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SLOT_W-1:0] out_slot,
  output logic              out_dispatched,
  output logic              out_last,
  output logic              out_slot_active,
  output logic [VAL_W-1:0]  out_slot_countdown,
  output logic [VAL_W-1:0]  out_slot_reload,
  output logic [ACNT_W-1:0] out_active_count
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);

  logic [COUNT_WIDTH-1:0] cd_mem [NUM_SLOTS];
  logic [COUNT_WIDTH-1:0] rl_mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]   cd_ok_r, rl_ok_r;
  logic [COUNT_WIDTH-1:0] cd_q_r, rl_q_r;
  logic                   cd_qv_r, rl_qv_r;

  logic [NUM_SLOTS-1:0]   act_r, pend_r, once_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [SLOT_W-1:0]      cur_r;
  logic [IDX_W-1:0]       idx_r;
  logic [2:0]             n_r;
  logic [SLOT_W-1:0]      tgt_r;
  logic [COUNT_WIDTH-1:0] val_r;
  logic                   ok_r;

  logic                   ov_r;
  logic [SLOT_W-1:0]      oslot_r;
  logic                   odisp_r, olast_r, oact_r;
  logic [VAL_W-1:0]       ocd_r, orl_r;
  logic [ACNT_W-1:0]      ocnt_r;

  logic [SLOT_W-1:0]            tgt_sel;
  logic [VAL_W+COUNT_WIDTH-1:0] val_ext;
  logic [IDX_W-1:0]             tgt_idx;
  logic [IDX_W+SLOT_W-1:0]      idx_ext;
  logic [SLOT_W-1:0]            idx_slot;
  logic [COUNT_WIDTH-1:0]       cd_rd, rl_rd;
  logic [VAL_W+COUNT_WIDTH-1:0] cd_ext, rl_ext;
  logic [CNT_W+ACNT_W-1:0]      cnt_ext, cnt_disp_ext;
  logic [CNT_W-1:0]             cnt_disp;
  logic [NUM_SLOTS-1:0]         hits, above;
  logic                         once_i, tick_live, tick_wrap;
  logic                         rd_en;
  logic [IDX_W-1:0]             rd_addr;
  logic                         cd_we, rl_we;
  logic [IDX_W-1:0]             cd_wa, rl_wa;
  logic [COUNT_WIDTH-1:0]       cd_wd, rl_wd;
  logic                         setup_op;

  assign tgt_sel  = in_use_current ? cur_r : in_slot;
  assign val_ext  = (VAL_W + COUNT_WIDTH)'(in_value);
  assign tgt_idx  = IDX_W'(tgt_r);
  assign idx_ext  = (IDX_W + SLOT_W)'(idx_r);
  assign idx_slot = idx_ext[SLOT_W-1:0];

  assign cd_rd    = cd_qv_r ? cd_q_r : '0;
  assign rl_rd    = rl_qv_r ? rl_q_r : '0;
  assign cd_ext   = (VAL_W + COUNT_WIDTH)'(cd_rd);
  assign rl_ext   = (VAL_W + COUNT_WIDTH)'(rl_rd);

  assign once_i       = once_r[idx_r];
  assign cnt_disp     = cnt_r - CNT_W'(once_i);
  assign cnt_ext      = (CNT_W + ACNT_W)'(cnt_r);
  assign cnt_disp_ext = (CNT_W + ACNT_W)'(cnt_disp);

  assign tick_live = act_r[idx_r] && (cd_rd != '0);
  assign tick_wrap = tick_live && (cd_rd == COUNT_WIDTH'(1));
  assign setup_op  = (cmd.op == OP_SETUP_PER) || (cmd.op == OP_SETUP_ONCE);

  assign hits = act_r & pend_r;
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      above[i] = (i > int'(idx_r));
    end
  end

  assign stat.idx_last  = (idx_r == IDX_W'(NUM_SLOTS - 1));
  assign stat.disp_hit  = hits[idx_r];
  assign stat.disp_last = (n_r == 3'(RES_MAX - 1)) || !(|(hits & above));
  assign stat.out_free  = !ov_r || !out_stall;

  // slot store ports
  assign rd_en   = cmd.rd_scan || cmd.rd_tgt;
  assign rd_addr = cmd.rd_scan ? idx_r : tgt_idx;

  always_comb begin
    cd_we = 1'b0;
    cd_wa = idx_r;
    cd_wd = tick_wrap ? rl_rd : (cd_rd - COUNT_WIDTH'(1));
    rl_we = 1'b0;
    rl_wa = tgt_idx;
    rl_wd = val_r;
    if (cmd.tick_step) begin
      cd_we = tick_live;
    end else if (cmd.apply && ok_r) begin
      cd_wa = tgt_idx;
      cd_wd = val_r;
      case (cmd.op)
        OP_SETUP_PER, OP_SETUP_ONCE: begin
          cd_we = 1'b1;
          rl_we = 1'b1;
        end
        OP_SET_CD: cd_we = 1'b1;
        OP_SET_RL: rl_we = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cd_we) begin
      cd_mem[cd_wa] <= cd_wd;
    end
    if (rl_we) begin
      rl_mem[rl_wa] <= rl_wd;
    end
    if (rd_en) begin
      cd_q_r  <= cd_mem[rd_addr];
      rl_q_r  <= rl_mem[rd_addr];
      cd_qv_r <= cd_ok_r[rd_addr];
      rl_qv_r <= rl_ok_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tgt_r <= tgt_sel;
      ok_r  <= (32'(tgt_sel) < NUM_SLOTS);
      val_r <= val_ext[COUNT_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cd_ok_r <= '0;
      rl_ok_r <= '0;
      act_r   <= '0;
      pend_r  <= '0;
      once_r  <= '0;
      cnt_r   <= '0;
      cur_r   <= '0;
      idx_r   <= '0;
      n_r     <= '0;
      ov_r    <= 1'b0;
    end else begin
      if (cd_we) begin
        cd_ok_r[cd_wa] <= 1'b1;
      end
      if (rl_we) begin
        rl_ok_r[rl_wa] <= 1'b1;
      end
      if (cmd.scan_clr) begin
        idx_r <= '0;
        n_r   <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + IDX_W'(1);
      end
      if (cmd.tick_step && tick_wrap) begin
        pend_r[idx_r] <= 1'b1;
      end
      if (cmd.disp_step) begin
        pend_r[idx_r] <= 1'b0;
        cur_r         <= idx_slot;
        n_r           <= n_r + 3'd1;
        if (once_i) begin
          act_r[idx_r] <= 1'b0;
          cnt_r        <= cnt_disp;
        end
      end
      if (cmd.apply && ok_r) begin
        case (cmd.op)
          OP_SETUP_PER, OP_SETUP_ONCE, OP_DROP: begin
            if (act_r[tgt_idx]) begin
              act_r[tgt_idx] <= 1'b0;
              cnt_r          <= cnt_r - CNT_W'(1);
            end
            if (setup_op) begin
              pend_r[tgt_idx] <= 1'b0;
              once_r[tgt_idx] <= (cmd.op == OP_SETUP_ONCE);
            end
          end
          OP_JOIN: begin
            if (!act_r[tgt_idx]) begin
              act_r[tgt_idx] <= 1'b1;
              cnt_r          <= cnt_r + CNT_W'(1);
            end
          end
          default: ;
        endcase
      end
      if (cmd.disp_step || cmd.st_out) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.disp_step) begin
      oslot_r <= idx_slot;
      odisp_r <= 1'b1;
      olast_r <= stat.disp_last;
      oact_r  <= !once_i;
      ocd_r   <= cd_ext[VAL_W-1:0];
      orl_r   <= rl_ext[VAL_W-1:0];
      ocnt_r  <= cnt_disp_ext[ACNT_W-1:0];
    end else if (cmd.st_out) begin
      oslot_r <= tgt_r;
      odisp_r <= 1'b0;
      olast_r <= 1'b1;
      oact_r  <= ok_r && act_r[tgt_idx];
      ocd_r   <= ok_r ? cd_ext[VAL_W-1:0] : '0;
      orl_r   <= ok_r ? rl_ext[VAL_W-1:0] : '0;
      ocnt_r  <= cnt_ext[ACNT_W-1:0];
    end
  end

  assign out_valid          = ov_r;
  assign out_slot           = oslot_r;
  assign out_dispatched     = odisp_r;
  assign out_last           = olast_r;
  assign out_slot_active    = oact_r;
  assign out_slot_countdown = ocd_r;
  assign out_slot_reload    = orl_r;
  assign out_active_count   = ocnt_r;

endmodule

@@ sv/time_slice_task_scheduler_top.sv @@
// channel  | ports                                              | direction
// in       | in_valid in_stall in_cmd in_slot in_use_current    | word in
//          | in_value                                           |
// out      | out_valid out_stall out_slot out_dispatched        | words out
//          | out_last out_slot_active out_slot_countdown        |
//          | out_slot_reload out_active_count                   |
//
// Tick and dispatch walk the slots through the single read port of the slot
// store, a read state and an execute state per slot, and output stalls can
// hold the walk; a dispatch that finds work ends at its last dispatched slot.
// Set-up, join, drop and set go through apply, read and output states.
// One word is in hand at a time; in_stall is high until its last result is
// in the output register. Synchronous active-low reset clears all slots.
module time_slice_task_scheduler_top
  import tss_pkg::*;
#(
  parameter int NUM_SLOTS   = 8,
  parameter int COUNT_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_cmd,
  input  logic [SLOT_W-1:0] in_slot,
  input  logic              in_use_current,
  input  logic [VAL_W-1:0]  in_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SLOT_W-1:0] out_slot,
  output logic              out_dispatched,
  output logic              out_last,
  output logic              out_slot_active,
  output logic [VAL_W-1:0]  out_slot_countdown,
  output logic [VAL_W-1:0]  out_slot_reload,
  output logic [ACNT_W-1:0] out_active_count
);

  tss_cmd_t  cmd;
  tss_stat_t stat;

  tss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_cmd   (in_cmd),
    .stat     (stat),
    .cmd      (cmd)
  );

  tss_dp #(
    .NUM_SLOTS   (NUM_SLOTS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_slot            (in_slot),
    .in_use_current     (in_use_current),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_slot           (out_slot),
    .out_dispatched     (out_dispatched),
    .out_last           (out_last),
    .out_slot_active    (out_slot_active),
    .out_slot_countdown (out_slot_countdown),
    .out_slot_reload    (out_slot_reload),
    .out_active_count   (out_active_count)
  );

endmodule

@@ sv/tss_chk.sv @@
module tss_chk
  import tss_pkg::*;
#(
  parameter int NUM_SLOTS = 8
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic [2:0]        in_cmd,
  input logic [SLOT_W-1:0] in_slot,
  input logic              in_use_current,
  input logic [VAL_W-1:0]  in_value,
  input logic              out_valid,
  input logic              out_stall,
  input logic [SLOT_W-1:0] out_slot,
  input logic              out_dispatched,
  input logic              out_last,
  input logic              out_slot_active,
  input logic [VAL_W-1:0]  out_slot_countdown,
  input logic [VAL_W-1:0]  out_slot_reload,
  input logic [ACNT_W-1:0] out_active_count
);

  // held result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_slot) && $stable(out_last)
      && $stable(out_dispatched) && $stable(out_slot_countdown)
      && $stable(out_slot_reload) && $stable(out_slot_active)
      && $stable(out_active_count))
    else $error("result word changed while stalled");

  // held input word
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_cmd) && $stable(in_slot)
      && $stable(in_use_current) && $stable(in_value))
    else $error("input word changed while stalled");

  // status words always close their command
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_dispatched |-> out_last)
    else $error("status word without last mark");

  // one word in hand at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken while busy");

  // an active slot implies a nonzero joined count
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    (NUM_SLOTS < 16) && out_valid && out_slot_active |-> out_active_count != '0)
    else $error("active slot with zero joined count");

endmodule

bind time_slice_task_scheduler_top tss_chk #(.NUM_SLOTS(NUM_SLOTS)) u_tss_chk (.*);

@@ tb/time_slice_task_scheduler_top_tb.sv @@
module time_slice_task_scheduler_top_tb;
  import tss_pkg::*;

  localparam int SLOTS       = 8;
  localparam int WORD_CYCLES = 2 * SLOTS + 3;
  localparam int IDLE_LIMIT  = 2000;

  typedef struct {
    logic [SLOT_W-1:0] slot;
    logic              dispatched;
    logic              last;
    logic              active;
    logic [VAL_W-1:0]  countdown;
    logic [VAL_W-1:0]  reload;
    logic [ACNT_W-1:0] joined;
  } slot_report_t;

  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_stall;
  logic [2:0]        in_cmd         = OP_TICK;
  logic [SLOT_W-1:0] in_slot        = '0;
  logic              in_use_current = 1'b0;
  logic [VAL_W-1:0]  in_value       = '0;
  logic              out_valid;
  logic              out_stall      = 1'b0;
  logic [SLOT_W-1:0] out_slot;
  logic              out_dispatched;
  logic              out_last;
  logic              out_slot_active;
  logic [VAL_W-1:0]  out_slot_countdown;
  logic [VAL_W-1:0]  out_slot_reload;
  logic [ACNT_W-1:0] out_active_count;

  // scheduler state as the testbench sees it
  bit [VAL_W-1:0]  slot_count  [SLOTS];
  bit [VAL_W-1:0]  slot_reload [SLOTS];
  bit              slot_due    [SLOTS];
  bit              slot_once   [SLOTS];
  bit              slot_joined [SLOTS];
  bit [ACNT_W-1:0] joined_total;
  bit [SLOT_W-1:0] last_run;

  slot_report_t reports_due[$];
  int           faults;
  int           words_sent;
  bit           quiet;
  int           stall_left;

  time_slice_task_scheduler_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_slot            (in_slot),
    .in_use_current     (in_use_current),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_slot           (out_slot),
    .out_dispatched     (out_dispatched),
    .out_last           (out_last),
    .out_slot_active    (out_slot_active),
    .out_slot_countdown (out_slot_countdown),
    .out_slot_reload    (out_slot_reload),
    .out_active_count   (out_active_count)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic slot_report_t report_of(int s, logic disp, logic fin);
    slot_report_t r;
    r.slot       = SLOT_W'(s);
    r.dispatched = disp;
    r.last       = fin;
    r.active     = slot_joined[s];
    r.countdown  = slot_count[s];
    r.reload     = slot_reload[s];
    r.joined     = joined_total;
    return r;
  endfunction

  function automatic void unjoin(int s);
    if (slot_joined[s]) begin
      slot_joined[s] = 1'b0;
      joined_total--;
    end
  endfunction

  function automatic void predict_reports(op_t op, logic [SLOT_W-1:0] slot, logic cur,
                                          logic [VAL_W-1:0] value);
    int           tgt;
    slot_report_t batch[$];
    tgt = cur ? int'(last_run) : int'(slot);
    case (op)
      OP_TICK: begin
        for (int s = 0; s < SLOTS; s++) begin
          if (slot_joined[s] && slot_count[s] != 0) begin
            slot_count[s]--;
            if (slot_count[s] == 0) begin
              slot_count[s] = slot_reload[s];
              slot_due[s]   = 1'b1;
            end
          end
        end
      end
      OP_DISPATCH: begin
        for (int s = 0; s < SLOTS && batch.size() < RES_MAX; s++) begin
          if (slot_joined[s] && slot_due[s]) begin
            slot_due[s] = 1'b0;
            last_run    = SLOT_W'(s);
            if (slot_once[s]) unjoin(s);
            batch.push_back(report_of(s, 1'b1, 1'b0));
          end
        end
      end
      OP_SETUP_PER, OP_SETUP_ONCE: begin
        unjoin(tgt);
        slot_count[tgt]  = value;
        slot_reload[tgt] = value;
        slot_due[tgt]    = 1'b0;
        slot_once[tgt]   = (op == OP_SETUP_ONCE);
      end
      OP_JOIN: if (!slot_joined[tgt]) begin
        slot_joined[tgt] = 1'b1;
        joined_total++;
      end
      OP_DROP:   unjoin(tgt);
      OP_SET_CD: slot_count[tgt] = value;
      OP_SET_RL: slot_reload[tgt] = value;
      default: ;
    endcase
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    else batch.push_back(report_of(tgt, 1'b0, 1'b1));
    foreach (batch[i]) reports_due.push_back(batch[i]);
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      faults++;
    end
  endfunction

  always @(posedge clk) begin
    slot_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (reports_due.size() == 0) begin
        $error("out_slot: expected no word, got %0h", out_slot);
        faults++;
      end else begin
        want = reports_due.pop_front();
        check_field("out_slot", 32'(want.slot), 32'(out_slot));
        check_field("out_dispatched", 32'(want.dispatched), 32'(out_dispatched));
        check_field("out_last", 32'(want.last), 32'(out_last));
        check_field("out_slot_active", 32'(want.active), 32'(out_slot_active));
        check_field("out_slot_countdown", 32'(want.countdown), 32'(out_slot_countdown));
        check_field("out_slot_reload", 32'(want.reload), 32'(out_slot_reload));
        check_field("out_active_count", 32'(want.joined), 32'(out_active_count));
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) stall_left--;
    else if (!quiet && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 9);
    out_stall <= (stall_left > 0);
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  task automatic send_word(input op_t op, input logic [SLOT_W-1:0] slot, input logic cur,
                           input logic [VAL_W-1:0] value);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_cmd         <= op;
    in_slot        <= slot;
    in_use_current <= cur;
    in_value       <= value;
    do @(posedge clk); while (in_stall);
    predict_reports(op, slot, cur, value);
    words_sent++;
  endtask

  task automatic send_random_word();
    op_t              op;
    logic [VAL_W-1:0] v;
    op = op_t'($urandom_range(0, 7));
    if ($urandom_range(0, 1)) v = 16'($urandom);
    else v = 16'($urandom_range(0, 5));
    send_word(op, SLOT_W'($urandom_range(0, 7)), $urandom_range(0, 3) == 0, v);
  endtask

  // set up a slot, join it, tick it down and dispatch, then maybe set, reload or drop it
  task automatic send_job();
    op_t               op;
    logic [SLOT_W-1:0] s;
    logic [VAL_W-1:0]  v;
    s = SLOT_W'($urandom_range(0, 7));
    if ($urandom_range(0, 1)) op = OP_SETUP_ONCE;
    else op = OP_SETUP_PER;
    if ($urandom_range(0, 7) == 0) v = 16'($urandom);
    else v = 16'($urandom_range(1, 4));
    send_word(op, s, 1'b0, v);
    send_word(OP_JOIN, s, 1'b0, 16'($urandom));
    repeat ($urandom_range(1, 4))
      send_word(OP_TICK, SLOT_W'($urandom_range(0, 7)), 1'b0, 16'($urandom));
    send_word(OP_DISPATCH, SLOT_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
              16'($urandom));
    case ($urandom_range(0, 3))
      0: send_word(OP_SET_CD, s, 1'b1, 16'($urandom_range(1, 3)));
      1: send_word(OP_DROP, s, 1'b1, 16'($urandom));
      2: send_word(OP_SET_RL, s, 1'b1, 16'($urandom_range(0, 4)));
      default: ;
    endcase
  endtask

  task automatic test_setup_and_join();
    send_word(OP_DISPATCH, 3'd7, 1'b0, 16'h0000);
    send_word(OP_SETUP_PER, 3'd0, 1'b0, 16'd2);
    send_word(OP_SETUP_ONCE, 3'd7, 1'b0, 16'd1);
    send_word(OP_SETUP_PER, 3'd3, 1'b0, 16'hFFFF);
    send_word(OP_JOIN, 3'd0, 1'b0, 16'h0000);
    send_word(OP_JOIN, 3'd7, 1'b0, 16'h0000);
    send_word(OP_JOIN, 3'd3, 1'b0, 16'h0000);
    send_word(OP_JOIN, 3'd0, 1'b0, 16'hFFFF);
  endtask

  task automatic test_tick_and_dispatch();
    send_word(OP_TICK, 3'd0, 1'b0, 16'h0000);
    send_word(OP_TICK, 3'd0, 1'b0, 16'h0000);
    send_word(OP_DISPATCH, 3'd0, 1'b0, 16'h0000);
  endtask

  task automatic test_zero_countdown();
    send_word(OP_SET_CD, 3'd3, 1'b0, 16'h0000);
    send_word(OP_TICK, 3'd7, 1'b1, 16'hFFFF);
  endtask

  task automatic test_current_slot();
    send_word(OP_SET_RL, 3'd0, 1'b1, 16'hFFFF);
    send_word(OP_JOIN, 3'd0, 1'b1, 16'h0000);
    send_word(OP_DROP, 3'd0, 1'b1, 16'h0000);
  endtask

  task automatic test_drop_rules();
    send_word(OP_DROP, 3'd5, 1'b0, 16'h0000);
    send_word(OP_SETUP_PER, 3'd0, 1'b0, 16'h0000);
    send_word(OP_SET_CD, 3'd3, 1'b0, 16'd1);
    send_word(OP_TICK, 3'd0, 1'b0, 16'h0000);
    send_word(OP_DROP, 3'd3, 1'b0, 16'h0000);
    send_word(OP_DISPATCH, 3'd3, 1'b0, 16'h0000);
    send_word(OP_JOIN, 3'd3, 1'b0, 16'h0000);
    send_word(OP_DISPATCH, 3'd0, 1'b0, 16'h0000);
  endtask

  task automatic test_random_traffic(input int count);
    int stop;
    stop = words_sent + count;
    while (words_sent < stop) begin
      if ($urandom_range(0, 9) < 6) send_job();
      else send_random_word();
    end
  endtask

  task automatic test_steady_tail(input int count);
    quiet = 1'b1;
    test_random_traffic(count);
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    test_setup_and_join();
    test_tick_and_dispatch();
    test_zero_countdown();
    test_current_slot();
    test_drop_rules();
    test_random_traffic(146);
    test_steady_tail(40);
    @(negedge clk);
    in_valid <= 1'b0;
    while (reports_due.size() > 0) @(posedge clk);
    repeat (WORD_CYCLES + 10) @(posedge clk);
    if (faults == 0 && reports_due.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
